[rtl/core/tti_pkg.sv]
// Shared types, constants and helper functions for the text to integer parser.
// Used by tti_parse, tti_format and text_to_integer_parser.
`timescale 1ns / 1ps

package tti_pkg;

  localparam int MaxLenDefault = 4096;
  localparam int CharW   = 8;
  localparam int BaseW   = 6;
  localparam int FmtW    = 2;
  localparam int ValueW  = 64;
  localparam int StatusW = 2;
  localparam int StopW   = 13;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 6;
  localparam int OutW    = 80;

  localparam logic [CfgIdxW-1:0] CFG_NUMBER_BASE   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_RESULT_FORMAT = 1'd1;

  localparam logic [BaseW-1:0] BASE_RESET = 6'd10;
  localparam logic [FmtW-1:0]  FMT_RESET  = 2'd1;
  localparam logic [BaseW-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BaseW-1:0] BASE_OCT   = 6'd8;
  localparam logic [BaseW-1:0] BASE_DEC   = 6'd10;
  localparam logic [BaseW-1:0] BASE_HEX   = 6'd16;
  localparam logic [BaseW-1:0] BASE_MAX   = 6'd36;
  localparam logic [BaseW-1:0] BASE_UNARY = 6'd1;
  localparam logic [BaseW-1:0] BASE_MIN   = 6'd2;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_NO_DIGITS = 2'd1;
  localparam logic [StatusW-1:0] ST_RANGE     = 2'd2;
  localparam logic [StatusW-1:0] ST_BAD_BASE  = 2'd3;

  typedef enum logic [FmtW-1:0] {
    FMT_U32 = 2'd0,
    FMT_S32 = 2'd1,
    FMT_U64 = 2'd2,
    FMT_S64 = 2'd3
  } fmt_t;

  typedef enum logic [5:0] {
    PH_SPACE  = 6'b000001,
    PH_START  = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_XPEND  = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic             ok;
    logic [BaseW-1:0] val;
  } digit_t;

  // Final parse state of one string, handed to the formatter.
  typedef struct packed {
    logic [ValueW-1:0] magnitude;
    logic [BaseW-1:0]  radix;
    logic              minus_seen;
    logic              overflow_seen;
    logic              digit_seen;
    logic [StopW-1:0]  stop_index;
  } final_t;

  function automatic digit_t digit_of(input logic [CharW-1:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.val = BaseW'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d.val = BaseW'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d.val = BaseW'(c - 8'h41 + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic base_bad(input logic [BaseW-1:0] b);
    return (b == BASE_UNARY) || (b > BASE_MAX);
  endfunction

endpackage

[rtl/core/tti_parse.sv]
// Per-character parse step: phase tracking, radix selection, digit accumulation
// with exact 64-bit overflow detection, and the final-state register. Uses tti_pkg.
`timescale 1ns / 1ps

module tti_parse import tti_pkg::*; #(
  parameter int MAX_LEN = MaxLenDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CharW-1:0] in_char,
  input  logic             in_last,
  input  logic [BaseW-1:0] number_base,
  output logic             step_ready,
  input  logic             fin_ready,
  output logic             fin_valid,
  output final_t           fin
);

  localparam int PosW = $clog2(MAX_LEN + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_LEN);

  phase_t            phase, phase_next, ph;
  logic [BaseW-1:0]  radix, radix_next, r, tr;
  logic [ValueW-1:0] magnitude, magnitude_next;
  logic              minus_seen, minus_seen_next;
  logic              overflow_seen, overflow_seen_next;
  logic              digit_seen, digit_seen_next;
  logic [PosW-1:0]   char_pos, char_pos_next;
  logic [PosW-1:0]   stop_pos, stop_pos_next;
  logic              start, start_num, take, step;
  digit_t            dg;
  logic [69:0]       prod;
  logic [70:0]       acc;
  logic [PosW+StopW-1:0] stop_ext;

  assign dg         = digit_of(in_char);
  assign prod       = 70'(magnitude) * 70'(tr);
  assign acc        = {1'b0, prod} + 71'(dg.val);
  assign step_ready = !in_last || !fin_valid || fin_ready;
  assign step       = in_valid && step_ready;
  assign stop_ext   = {{StopW{1'b0}}, stop_pos_next};

  always_comb begin
    start = (char_pos == '0) && (phase == PH_SPACE);
    r     = start ? number_base : radix;
    ph    = (start && base_bad(number_base)) ? PH_DONE : phase;

    phase_next         = ph;
    radix_next         = r;
    magnitude_next     = magnitude;
    minus_seen_next    = minus_seen;
    overflow_seen_next = overflow_seen;
    digit_seen_next    = digit_seen;
    char_pos_next      = char_pos;
    stop_pos_next      = stop_pos;
    start_num          = 1'b0;
    take               = 1'b0;
    tr                 = r;

    if (char_pos < MaxPos) begin
      char_pos_next = char_pos + 1'b1;
      unique case (ph)
        PH_SPACE: begin
          if (is_space(in_char)) begin
            phase_next = PH_SPACE;
          end else if (in_char == 8'h2D) begin
            minus_seen_next = 1'b1;
            phase_next      = PH_START;
          end else if (in_char == 8'h2B) begin
            phase_next = PH_START;
          end else begin
            start_num = 1'b1;
          end
        end
        PH_START: start_num = 1'b1;
        PH_ZERO: begin
          if (in_char == 8'h78 || in_char == 8'h58) begin
            phase_next = PH_XPEND;
          end else begin
            tr   = (r == BASE_AUTO) ? BASE_OCT : r;
            take = 1'b1;
          end
        end
        // a non-hex char after "0x" fails the digit check and ends the number
        PH_XPEND: begin
          tr   = BASE_HEX;
          take = 1'b1;
        end
        PH_DIGITS: take = 1'b1;
        PH_DONE:   phase_next = PH_DONE;
        default:   phase_next = PH_DONE;
      endcase

      if (start_num) begin
        if ((r == BASE_AUTO || r == BASE_HEX) && in_char == 8'h30) begin
          digit_seen_next = 1'b1;
          magnitude_next  = '0;
          stop_pos_next   = char_pos + 1'b1;
          phase_next      = PH_ZERO;
        end else begin
          tr   = (r == BASE_AUTO) ? BASE_DEC : r;
          take = 1'b1;
        end
      end

      if (take) begin
        radix_next = tr;
        if (tr < BASE_MIN || !dg.ok || dg.val >= tr) begin
          phase_next = PH_DONE;
        end else begin
          phase_next      = PH_DIGITS;
          digit_seen_next = 1'b1;
          stop_pos_next   = char_pos + 1'b1;
          if (acc[70:64] != '0) begin
            overflow_seen_next = 1'b1;
          end else begin
            magnitude_next = acc[63:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SPACE;
      radix         <= '0;
      magnitude     <= '0;
      minus_seen    <= 1'b0;
      overflow_seen <= 1'b0;
      digit_seen    <= 1'b0;
      char_pos      <= '0;
      stop_pos      <= '0;
    end else if (step) begin
      if (in_last) begin
        phase         <= PH_SPACE;
        radix         <= '0;
        magnitude     <= '0;
        minus_seen    <= 1'b0;
        overflow_seen <= 1'b0;
        digit_seen    <= 1'b0;
        char_pos      <= '0;
        stop_pos      <= '0;
      end else begin
        phase         <= phase_next;
        radix         <= radix_next;
        magnitude     <= magnitude_next;
        minus_seen    <= minus_seen_next;
        overflow_seen <= overflow_seen_next;
        digit_seen    <= digit_seen_next;
        char_pos      <= char_pos_next;
        stop_pos      <= stop_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (step && in_last) begin
      fin_valid <= 1'b1;
    end else if (fin_ready) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      fin.magnitude     <= magnitude_next;
      fin.radix         <= radix_next;
      fin.minus_seen    <= minus_seen_next;
      fin.overflow_seen <= overflow_seen_next;
      fin.digit_seen    <= digit_seen_next;
      fin.stop_index    <= stop_ext[StopW-1:0];
    end
  end

endmodule

[rtl/core/tti_format.sv]
// Result formatting: status, saturation and two's complement negation per
// result format, into the output register. Uses tti_pkg.
`timescale 1ns / 1ps

module tti_format import tti_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            fin_valid,
  input  final_t          fin,
  input  logic [FmtW-1:0] result_format,
  output logic            fin_ready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [OutW-1:0] m_tdata     // number_value[63:0], parse_status[65:64],
                                      // stop_index[78:66], zero pad[79]
);

  logic [ValueW-1:0]  value, neg;
  logic [StatusW-1:0] status;
  logic [StopW-1:0]   stop;
  logic               ovf;
  fmt_t               fmt;

  assign fin_ready = !m_tvalid || m_tready;
  assign neg       = '0 - fin.magnitude;
  assign ovf       = fin.overflow_seen;
  assign fmt       = fmt_t'(result_format);

  always_comb begin
    value  = '0;
    status = ST_OK;
    stop   = '0;
    if (base_bad(fin.radix)) begin
      status = ST_BAD_BASE;
    end else if (!fin.digit_seen) begin
      status = ST_NO_DIGITS;
    end else begin
      stop = fin.stop_index;
      case (fmt)
        FMT_U32: begin
          if (ovf || fin.magnitude[63:32] != '0) begin
            value  = 64'h0000_0000_FFFF_FFFF;
            status = ST_RANGE;
          end else begin
            value = fin.minus_seen ? {32'd0, neg[31:0]} : fin.magnitude;
          end
        end
        FMT_S32: begin
          if (fin.minus_seen) begin
            if (ovf || fin.magnitude > 64'h0000_0000_8000_0000) begin
              value  = 64'h0000_0000_8000_0000;
              status = ST_RANGE;
            end else begin
              value = {32'd0, neg[31:0]};
            end
          end else if (ovf || fin.magnitude > 64'h0000_0000_7FFF_FFFF) begin
            value  = 64'h0000_0000_7FFF_FFFF;
            status = ST_RANGE;
          end else begin
            value = fin.magnitude;
          end
        end
        FMT_U64: begin
          if (ovf) begin
            value  = '1;
            status = ST_RANGE;
          end else begin
            value = fin.minus_seen ? neg : fin.magnitude;
          end
        end
        FMT_S64: begin
          if (fin.minus_seen) begin
            if (ovf || fin.magnitude > 64'h8000_0000_0000_0000) begin
              value  = 64'h8000_0000_0000_0000;
              status = ST_RANGE;
            end else begin
              value = neg;
            end
          end else if (ovf || fin.magnitude[63]) begin
            value  = 64'h7FFF_FFFF_FFFF_FFFF;
            status = ST_RANGE;
          end else begin
            value = fin.magnitude;
          end
        end
        default: value = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_ready) begin
      m_tvalid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin_valid) begin
      m_tdata <= {1'b0, stop, status, value};
    end
  end

endmodule

[rtl/core/text_to_integer_parser.sv]
// Streaming strtol-style text to integer parser, top level.
// Holds the config registers and input register; uses tti_pkg, tti_parse, tti_format.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid/s_tready    tdata: text_char; tlast: last_char
//   m_*       out   m_tvalid/m_tready    tdata: number_value, parse_status, stop_index
//   cfg_*     in    cfg_we               cfg_index selects register, cfg_data value
//
// One character per cycle, sustained. The parse step (with the 64x6 multiply-add) writes
// the final-state register; the format step then writes the output register at m_*.
// The input stalls only when a last character finds a result held in the final-state
// register while m_* also holds one and m_tready is low; characters behind it wait too.
// Reset is synchronous and restores number_base 10 and result_format 1.
`timescale 1ns / 1ps

module text_to_integer_parser import tti_pkg::*; #(
  parameter int MAX_LEN = MaxLenDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [CharW-1:0]   s_tdata,    // text_char[7:0]
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OutW-1:0]    m_tdata,    // number_value[63:0], parse_status[65:64],
                                         // stop_index[78:66], zero pad[79]
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  logic [BaseW-1:0] number_base;
  logic [FmtW-1:0]  result_format;
  logic             in_valid, in_last, step_ready, fin_valid, fin_ready;
  logic [CharW-1:0] in_char;
  final_t           fin;

  assign s_tready = !in_valid || step_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base   <= BASE_RESET;
      result_format <= FMT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUMBER_BASE:   number_base   <= cfg_data;
        CFG_RESULT_FORMAT: result_format <= cfg_data[FmtW-1:0];
        default:           number_base   <= number_base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  tti_parse #(
    .MAX_LEN(MAX_LEN)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_char    (in_char),
    .in_last    (in_last),
    .number_base(number_base),
    .step_ready (step_ready),
    .fin_ready  (fin_ready),
    .fin_valid  (fin_valid),
    .fin        (fin)
  );

  tti_format u_format (
    .clk          (clk),
    .rst          (rst),
    .fin_valid    (fin_valid),
    .fin          (fin),
    .result_format(result_format),
    .fin_ready    (fin_ready),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule

[test/tb_text_to_integer_parser.sv]
// Testbench for text_to_integer_parser: sends strings one character per item,
// predicts every parse result and checks it against the output stream.
// Depends on tti_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_text_to_integer_parser;
  import tti_pkg::*;

  localparam int MaxLen      = MaxLenDefault;
  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [StatusW-1:0] status;
    logic [StopW-1:0]   stop;
  } parse_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [CharW-1:0]   s_tdata = '0;    // text_char[7:0]
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OutW-1:0]    m_tdata;         // number_value[63:0], parse_status[65:64],
                                       // stop_index[78:66], zero pad[79]
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  text_to_integer_parser #(.MAX_LEN(MaxLen)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register shadows
  logic [BaseW-1:0] base_cfg = BASE_RESET;
  fmt_t             fmt_cfg  = FMT_S32;

  // parser state of the string in flight
  phase_t            ps_phase;
  logic [BaseW-1:0]  ps_radix;
  logic [ValueW-1:0] ps_mag;
  logic              ps_minus;
  logic              ps_ovf;
  logic              ps_digits;
  int                ps_pos;
  int                ps_stop;

  parse_result_t expected_results[$];
  int            fail_count     = 0;
  int            cycle_count    = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;

  function automatic int digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "z") return c - "a" + 10;
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    return 99;
  endfunction

  function automatic logic white(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void clear_parse();
    ps_phase  = PH_SPACE;
    ps_radix  = '0;
    ps_mag    = '0;
    ps_minus  = 1'b0;
    ps_ovf    = 1'b0;
    ps_digits = 1'b0;
    ps_pos    = 0;
    ps_stop   = 0;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    int d;
    logic [ValueW-1:0] lim;
    d = digit_value(c);
    if (ps_radix < BASE_MIN || d >= int'(ps_radix)) begin
      ps_phase = PH_DONE;
      return;
    end
    ps_phase  = PH_DIGITS;
    ps_digits = 1'b1;
    ps_stop   = ps_pos + 1;
    lim = ({ValueW{1'b1}} - ValueW'(d)) / ValueW'(ps_radix);
    if (ps_mag > lim) ps_ovf = 1'b1;
    else ps_mag = ps_mag * ValueW'(ps_radix) + ValueW'(d);
  endfunction

  function automatic void start_number(input logic [7:0] c);
    if ((ps_radix == BASE_AUTO || ps_radix == BASE_HEX) && c == "0") begin
      ps_digits = 1'b1;
      ps_mag    = '0;
      ps_stop   = ps_pos + 1;
      ps_phase  = PH_ZERO;
      return;
    end
    if (ps_radix == BASE_AUTO) ps_radix = BASE_DEC;
    take_digit(c);
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    case (ps_phase)
      PH_SPACE: begin
        if (white(c)) return;
        if (c == "-") begin
          ps_minus = 1'b1;
          ps_phase = PH_START;
        end else if (c == "+") begin
          ps_phase = PH_START;
        end else begin
          start_number(c);
        end
      end
      PH_START: start_number(c);
      PH_ZERO: begin
        if (c == "x" || c == "X") begin
          ps_phase = PH_XPEND;
        end else begin
          if (ps_radix == BASE_AUTO) ps_radix = BASE_OCT;
          take_digit(c);
        end
      end
      PH_XPEND: begin
        if (digit_value(c) < 16) begin
          ps_radix = BASE_HEX;
          take_digit(c);
        end else begin
          ps_phase = PH_DONE;
        end
      end
      PH_DIGITS: take_digit(c);
      default: ;
    endcase
  endfunction

  // Advances the prediction by one accepted character; queues a result on the last one.
  function automatic void accept_char(input logic [7:0] c, input logic last);
    parse_result_t r;
    logic [ValueW-1:0] neg;
    if (ps_pos == 0 && ps_phase == PH_SPACE) begin
      ps_radix = base_cfg;
      if (base_cfg == BASE_UNARY || base_cfg > BASE_MAX) ps_phase = PH_DONE;
    end
    if (ps_pos < MaxLen) begin
      parse_char(c);
      ps_pos++;
    end
    if (!last) return;
    r = '0;
    neg = '0 - ps_mag;
    if (ps_radix == BASE_UNARY || ps_radix > BASE_MAX) begin
      r.status = ST_BAD_BASE;
    end else if (!ps_digits) begin
      r.status = ST_NO_DIGITS;
    end else begin
      r.status = ST_OK;
      r.stop   = StopW'(ps_stop);
      case (fmt_cfg)
        FMT_U32: begin
          if (ps_ovf || ps_mag > 64'hFFFF_FFFF) begin
            r.value  = 64'hFFFF_FFFF;
            r.status = ST_RANGE;
          end else begin
            r.value = ps_minus ? (neg & 64'hFFFF_FFFF) : ps_mag;
          end
        end
        FMT_S32: begin
          if (ps_minus) begin
            if (ps_ovf || ps_mag > 64'h8000_0000) begin
              r.value  = 64'h8000_0000;
              r.status = ST_RANGE;
            end else begin
              r.value = neg & 64'hFFFF_FFFF;
            end
          end else if (ps_ovf || ps_mag > 64'h7FFF_FFFF) begin
            r.value  = 64'h7FFF_FFFF;
            r.status = ST_RANGE;
          end else begin
            r.value = ps_mag;
          end
        end
        FMT_U64: begin
          if (ps_ovf) begin
            r.value  = {ValueW{1'b1}};
            r.status = ST_RANGE;
          end else begin
            r.value = ps_minus ? neg : ps_mag;
          end
        end
        default: begin
          if (ps_minus) begin
            if (ps_ovf || ps_mag > 64'h8000_0000_0000_0000) begin
              r.value  = 64'h8000_0000_0000_0000;
              r.status = ST_RANGE;
            end else begin
              r.value = neg;
            end
          end else if (ps_ovf || ps_mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
            r.value  = 64'h7FFF_FFFF_FFFF_FFFF;
            r.status = ST_RANGE;
          end else begin
            r.value = ps_mag;
          end
        end
      endcase
    end
    expected_results.push_back(r);
    clear_parse();
  endfunction

  always @(negedge clk) begin
    m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.value  = m_tdata[63:0];
      got.status = m_tdata[65:64];
      got.stop   = m_tdata[78:66];
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: value %h status %0d stop %0d",
                 $time, got.value, got.status, got.stop);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: number_value expected %h actual %h", $time, want.value, got.value);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: parse_status expected %0d actual %0d", $time, want.status,
                   got.status);
          fail_count++;
        end
        if (got.stop !== want.stop) begin
          $display("%0t: stop_index expected %0d actual %0d", $time, want.stop, got.stop);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sends one string; valid stays up after the last item until the caller idles.
  task automatic send_bytes(input logic [7:0] text[$]);
    for (int i = 0; i < text.size(); i++) begin
      @(negedge clk);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= text[i];
      s_tlast  <= (i == text.size() - 1);
      do @(posedge clk); while (!s_tready);
      accept_char(text[i], i == text.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NUMBER_BASE) base_cfg = val;
    else fmt_cfg = fmt_t'(val[FmtW-1:0]);
  endtask

  task automatic set_config(input logic [BaseW-1:0] base, input fmt_t fmt);
    wait_idle();
    write_reg(CFG_NUMBER_BASE, base);
    write_reg(CFG_RESULT_FORMAT, CfgW'(fmt));
  endtask

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return 8'(8'h30 + d);
    return 8'(($urandom_range(1) ? 8'h61 : 8'h41) + d - 10);
  endfunction

  function automatic logic [7:0] white_char();
    int r;
    r = $urandom_range(9, 14);
    return (r == 14) ? 8'h20 : 8'(r);
  endfunction

  // Mostly well-formed numbers with random content, then broken sequences and noise.
  task automatic build_string(ref logic [7:0] q[$]);
    int kind;
    int radix;
    int ndig;
    int mode;
    logic all_max;
    q.delete();
    kind = $urandom_range(99);
    radix = (base_cfg == BASE_UNARY || base_cfg > BASE_MAX) ? 10 : int'(base_cfg);
    if (kind < 90) begin
      repeat ($urandom_range(0, 3)) q.push_back(white_char());
      case ($urandom_range(2))
        0: q.push_back("-");
        1: q.push_back("+");
        default: ;
      endcase
    end
    if (kind < 75) begin
      mode = $urandom_range(2);
      if (radix == 0 && mode == 0) begin
        radix = 10;
        q.push_back(digit_char($urandom_range(1, 9)));
      end else if (radix == 0 && mode == 1) begin
        radix = 8;
        q.push_back("0");
      end else if (radix == 0 || (radix == 16 && mode == 0)) begin
        radix = 16;
        q.push_back("0");
        q.push_back($urandom_range(1) ? "x" : "X");
      end
      ndig = ($urandom_range(3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 12);
      all_max = ($urandom_range(3) == 0);
      repeat (ndig) q.push_back(digit_char(all_max ? radix - 1 : $urandom_range(radix - 1)));
      if ($urandom_range(1)) begin
        repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(255)));
      end
    end else if (kind < 90) begin
      case ($urandom_range(3))
        0: ;
        1: begin
          q.push_back("0");
          q.push_back($urandom_range(1) ? "x" : "X");
          q.push_back(8'($urandom_range(255)));
        end
        2: begin
          if (radix == 0) radix = 10;
          q.push_back(digit_char($urandom_range(radix - 1)));
          if (radix < 36) q.push_back(digit_char($urandom_range(radix, 35)));
          q.push_back(digit_char($urandom_range(radix - 1)));
        end
        default: begin
          q.push_back($urandom_range(1) ? "-" : "+");
          q.push_back(digit_char($urandom_range(9)));
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(255)));
    end
    if (q.size() == 0) q.push_back(white_char());
  endtask

  task automatic run_random(input int idle_pct, input int stall_pct, input int nchars);
    logic [7:0] q[$];
    logic [BaseW-1:0] base;
    int sent;
    int nstr;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    nstr = 0;
    while (sent < nchars) begin
      if (nstr % 8 == 0) begin
        case ($urandom_range(9))
          0: base = BASE_AUTO;
          1: base = BASE_HEX;
          2: base = BASE_OCT;
          3: base = BASE_DEC;
          4: base = BASE_MIN;
          5: base = BASE_MAX;
          6: base = BASE_UNARY;
          7: base = BaseW'($urandom_range(37, 63));
          default: base = BaseW'($urandom_range(2, 36));
        endcase
        set_config(base, fmt_t'($urandom_range(3)));
      end
      build_string(q);
      sent += q.size();
      send_bytes(q);
      nstr++;
    end
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_reset_defaults();
    logic [7:0] q[$];
    send_text(" -123");
    send_text("+42");
    q = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, "7", 8'hFF};
    send_bytes(q);
  endtask

  task automatic test_prefixes();
    set_config(BASE_AUTO, FMT_S64);
    send_text("0x1F");
    send_text("0X");
    send_text("0xg");
    send_text("017");
    send_text("08");
    send_text("-0x7fffffffffffffff");
    set_config(BASE_HEX, FMT_U64);
    send_text("0XfF");
    send_text("Ab");
  endtask

  task automatic test_radix_extremes();
    set_config(BASE_MIN, FMT_U32);
    send_text("1012");
    set_config(BASE_MAX, FMT_U64);
    send_text("zZ9");
    set_config(BASE_UNARY, FMT_S32);
    send_text("123");
    set_config({BaseW{1'b1}}, FMT_S32);
    send_text("5");
  endtask

  task automatic test_range_limits();
    set_config(BASE_DEC, FMT_U32);
    send_text("4294967296");
    send_text("-1");
    set_config(BASE_DEC, FMT_S32);
    send_text("-2147483648");
    send_text("2147483648");
    set_config(BASE_DEC, FMT_U64);
    send_text("18446744073709551615");
    send_text("18446744073709551616");
    set_config(BASE_DEC, FMT_S64);
    send_text("-9223372036854775809");
    send_text("9223372036854775807");
  endtask

  task automatic test_no_digits();
    logic [7:0] q[$];
    set_config(BASE_DEC, FMT_S32);
    send_text("  ");
    send_text("-");
    send_text("+x");
    q = '{8'h00, "1", "2"};
    send_bytes(q);
    q = '{"4", 8'h00, "5"};
    send_bytes(q);
  endtask

  // Characters at and past MAX_LEN are dropped.
  task automatic test_long_strings();
    logic [7:0] q[$];
    set_config(BASE_DEC, FMT_U64);
    repeat (MaxLen + 4) q.push_back("0");
    q.push_back("7");
    send_bytes(q);
    q.delete();
    repeat (MaxLen - 2) q.push_back(8'h20);
    q.push_back("1");
    q.push_back("2");
    q.push_back("3");
    send_bytes(q);
  endtask

  initial begin
    clear_parse();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_prefixes();
    test_radix_extremes();
    test_range_limits();
    test_no_digits();
    test_long_strings();
    run_random(0, 0, 375);
    run_random(80, 0, 375);
    run_random(0, 80, 375);
    run_random(11, 11, 375);
    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
